FILE: design/bchcc_pkg.sv
// ----------------------------------------------------------------------------
// bchcc_pkg - shared constants and step functions for the BCH(31,21) corrector
// Holds the generator, syndrome feedback, error pattern table and the
// combinational step functions used by each pipeline stage.
// ----------------------------------------------------------------------------
package bchcc_pkg;

	localparam logic [31:0] DATA_MASK    = 32'hFFFF_F800;
	localparam logic [31:0] GEN_ALIGNED  = 32'hED20_0000;
	localparam logic [10:0] SYN_FEEDBACK = 11'h769;
	localparam logic [9:0]  LEAD_PATTERN = 10'h3B4;

	localparam int CODE_BITS     = 31;
	localparam int PATTERN_COUNT = 31;
	localparam int DIV_STEPS     = 7;
	localparam int WALK_STEPS    = 8;

	localparam logic [9:0] ERR_PATTERNS [PATTERN_COUNT] = '{
		10'h3B4, 10'h26E, 10'h359, 10'h076, 10'h255, 10'h0F0, 10'h216, 10'h365,
		10'h068, 10'h25A, 10'h343, 10'h07B, 10'h1E7, 10'h129, 10'h14E, 10'h2C9,
		10'h0BE, 10'h231, 10'h0C2, 10'h20F, 10'h0DD, 10'h1B4, 10'h2B4, 10'h334,
		10'h3F4, 10'h394, 10'h3A4, 10'h3BC, 10'h3B0, 10'h3B6, 10'h3B5
	};

	typedef struct packed {
		logic [9:0]  syn;
		logic [31:0] fixed;
	} walk_t;

	// one slice of the long division by the aligned generator
	function automatic logic [31:0] div_steps(input logic [31:0] rem_in);
		logic [31:0] rem;
		rem = rem_in;
		for (int k = 0; k < DIV_STEPS; k++) begin
			if (rem[31])
				rem = rem ^ GEN_ALIGNED;
			rem = {rem[30:0], 1'b0};
		end
		return rem;
	endfunction

	// parallel compare against the single and double error patterns
	function automatic logic in_pattern_set(input logic [9:0] syn);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < PATTERN_COUNT; k++)
			hit = hit | (ERR_PATTERNS[k] == syn);
		return hit;
	endfunction

	// one slice of the meggitt walk, positions first .. first+WALK_STEPS-1 that lie below CODE_BITS
	function automatic walk_t walk_steps(input logic [9:0] syn_in, input logic [31:0] cw,
			input logic [31:0] fixed_in, input int first);
		walk_t w;
		logic  hit;
		int    pos;
		w.syn   = syn_in;
		w.fixed = fixed_in;
		for (int k = 0; k < WALK_STEPS; k++) begin
			pos = first + k;
			if (pos < CODE_BITS) begin
				hit = in_pattern_set(w.syn);
				if (hit)
					w.syn = w.syn ^ LEAD_PATTERN;
				w.fixed[31 - pos] = cw[31 - pos] ^ hit;
				if (w.syn[9])
					w.syn = {w.syn[8:0], 1'b0} ^ SYN_FEEDBACK[9:0];
				else
					w.syn = {w.syn[8:0], 1'b0};
			end
		end
		return w;
	endfunction

endpackage

FILE: design/bch_codeword_corrector.sv
// ----------------------------------------------------------------------------
// bch_codeword_corrector - pipelined BCH(31,21) pager codeword corrector
// Syndrome by long division over three stages, then a Meggitt walk over bits
// 31..1 spread over four stages, then a registered result select.
// ----------------------------------------------------------------------------
// the result beat of a taken start passes stages s1 to s7, then the registered result select
// throughput: one codeword per cycle, set by the 7-stage pipeline; busy stays low
// each stage does 7 division steps or up to 8 walk steps on a 10-bit syndrome
// reset: arst_n clears all valid bits and the done strobe; no result is in flight
// after reset, and the receiver cannot stall the output
module bch_codeword_corrector
	import bchcc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] codeword,
	output logic        done,
	output logic [31:0] corrected_word,
	output logic        decode_ok
);

	logic        take;
	logic [6:0]  vld_s;
	logic [31:0] cw_s1, cw_s2, cw_s3, cw_s4, cw_s5, cw_s6, cw_s7;
	logic [31:0] rem_s1, rem_s2;
	logic [9:0]  syn_s3, syn_s4, syn_s5, syn_s6, syn_s7;
	logic        zero_s3, zero_s4, zero_s5, zero_s6, zero_s7;
	logic [31:0] fix_s4, fix_s5, fix_s6, fix_s7;
	logic [31:0] rem3;
	logic [9:0]  syn3;
	walk_t       w4, w5, w6, w7;
	logic        done_q, ok_q;
	logic [31:0] word_q;

	assign busy = 1'b0;
	assign take = start & ~busy;

	// division slices and syndrome
	assign rem3 = div_steps(rem_s2);
	assign syn3 = rem3[31:22] ^ cw_s2[10:1];

	// meggitt walk slices
	assign w4 = walk_steps(syn_s3, cw_s3, 32'h0, 0);
	assign w5 = walk_steps(syn_s4, cw_s4, fix_s4, WALK_STEPS);
	assign w6 = walk_steps(syn_s5, cw_s5, fix_s5, 2 * WALK_STEPS);
	assign w7 = walk_steps(syn_s6, cw_s6, fix_s6, 3 * WALK_STEPS);

	// valid bits and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_s  <= {vld_s[5:0], take};
			done_q <= vld_s[6];
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		cw_s1   <= codeword;
		rem_s1  <= div_steps(codeword & DATA_MASK);
		cw_s2   <= cw_s1;
		rem_s2  <= div_steps(rem_s1);
		cw_s3   <= cw_s2;
		syn_s3  <= syn3;
		zero_s3 <= (syn3 == 10'h0);
		cw_s4   <= cw_s3;
		syn_s4  <= w4.syn;
		fix_s4  <= w4.fixed;
		zero_s4 <= zero_s3;
		cw_s5   <= cw_s4;
		syn_s5  <= w5.syn;
		fix_s5  <= w5.fixed;
		zero_s5 <= zero_s4;
		cw_s6   <= cw_s5;
		syn_s6  <= w6.syn;
		fix_s6  <= w6.fixed;
		zero_s6 <= zero_s5;
		cw_s7   <= cw_s6;
		syn_s7  <= w7.syn;
		fix_s7  <= w7.fixed;
		zero_s7 <= zero_s6;
	end

	// result select: clean pass-through, corrected word, or uncorrectable
	always_ff @(posedge clk) begin
		if (zero_s7) begin
			word_q <= cw_s7;
			ok_q   <= 1'b1;
		end else if (syn_s7 != 10'h0) begin
			word_q <= cw_s7;
			ok_q   <= 1'b0;
		end else begin
			word_q <= {fix_s7[31:1], 1'b0};
			ok_q   <= 1'b1;
		end
	end

	assign done           = done_q;
	assign corrected_word = word_q;
	assign decode_ok      = ok_q;

endmodule

FILE: design/bchcc_checker.sv
// ----------------------------------------------------------------------------
// bchcc_checker - port-level checks for the codeword corrector
// Watches latency, result count and pass-through behaviour from the ports.
// ----------------------------------------------------------------------------
module bchcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [31:0] codeword,
	input logic        done,
	input logic [31:0] corrected_word,
	input logic        decode_ok
);

	logic [3:0] age_q;
	logic       warm;

	// cycles since reset, saturating once the pipeline history is valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			age_q <= '0;
		else if (!warm)
			age_q <= age_q + 4'd1;
	end

	assign warm = (age_q == 4'd9);

	// pipeline never pushes back
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");

	// exactly one result beat per accepted beat, fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n || !warm)
		done == $past(start && !busy, 8)) else $error("result beat out of step");

	// uncorrectable words come back untouched
	a_fail_passthru: assert property (@(posedge clk) disable iff (!arst_n || !warm)
		done && !decode_ok |-> corrected_word == $past(codeword, 8))
		else $error("uncorrectable word altered");

	// parity bit survives only when the word comes back unchanged
	a_parity_bit: assert property (@(posedge clk) disable iff (!arst_n || !warm)
		done && corrected_word[0] |-> corrected_word == $past(codeword, 8))
		else $error("parity bit set on corrected word");

endmodule

bind bch_codeword_corrector bchcc_checker u_bchcc_checker (.*);
